// ===== rtl/core/lru_key_cache_top_macros.svh =====
// assertion macros for the lru key cache
// expects clk and rst_n in the scope of the module that uses them
`ifndef LRU_KEY_CACHE_TOP_MACROS_SVH
`define LRU_KEY_CACHE_TOP_MACROS_SVH

// condition holds at every clock edge out of reset
`define LKC_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define LKC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define LKC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lkc_pkg.sv =====
// shared types and constants for the lru key cache
// no dependencies
package lkc_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_W        = 32;
  localparam int CNT_OUT_W    = 5;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_CHECK  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t             command;
    logic [KEY_W-1:0] key;
    logic             load_ok;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic                 inserted;
    logic                 evicted_valid;
    logic [KEY_W-1:0]     evicted_key;
    logic [CNT_OUT_W-1:0] entry_count;
  } out_item_t;

  // what every cell sees of the current transaction
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             lookup;
    logic             insert_new;
  } cell_bcast_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } cell_link_t;

endpackage

// ===== rtl/core/lkc_if.sv =====
// valid/ready channels of the lru key cache
// depends on lkc_pkg
interface lkc_in_if;
  import lkc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lkc_out_if;
  import lkc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/lkc_cell.sv =====
// one slot of the recency stack: key, valid bit, compare and shift
// depends on lkc_pkg
module lkc_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  lkc_pkg::cell_bcast_t bcast,
  input  lkc_pkg::cell_link_t  up_in,
  input  logic                down_valid,
  input  logic                shift_in,
  output lkc_pkg::cell_link_t  link_out,
  output logic                match,
  output logic                shift_out
);
  import lkc_pkg::*;

  logic             valid_r;
  logic             valid_nxt;
  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] key_nxt;
  logic             shift_here;

  assign match      = valid_r && (key_r == bcast.key);
  // shift once the hit slot or an eviction lies at or below this one
  assign shift_here = valid_r && (shift_in || (match && bcast.lookup));
  assign shift_out  = shift_here;
  assign link_out   = '{valid: valid_r, key: key_r};

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    if (shift_here) begin
      valid_nxt = 1'b1;
      // top valid slot takes the incoming key as most recent
      key_nxt   = up_in.valid ? up_in.key : bcast.key;
    end else if (bcast.insert_new && !valid_r && down_valid) begin
      valid_nxt = 1'b1;
      key_nxt   = bcast.key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ===== rtl/core/lru_key_cache_top.sv =====
// result: registered and shown in the cycle after the transaction is accepted
// throughput: one transaction per cycle without back-pressure; compare, reorder
//   and evict in a single pass of the cell row (shift chain ripples across CAPACITY cells)
// a new transaction is taken while the previous result waits, if out_chan.ready
// reset: synchronous, clears all valid bits, the entry count and the output
//   valid flag; no clearing pass, keys are left as they are
`include "lru_key_cache_top_macros.svh"

// top level of the lru key cache: row of cells, counter, result register
// depends on lkc_pkg, lkc_if, lkc_cell
module lru_key_cache_top #(
  parameter int CAPACITY = lkc_pkg::CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lkc_in_if.sink    in_chan,
  lkc_out_if.source out_chan
);
  import lkc_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  // transaction decode
  logic        acc;
  cell_bcast_t bcast;
  logic        hit;
  logic        inserted;
  logic        evict;
  logic        full;

  // cell row wiring
  cell_link_t          cell_link [CAPACITY];
  cell_link_t          up_link   [CAPACITY];
  logic [CAPACITY-1:0] down_vld;
  logic [CAPACITY-1:0] shift_in;
  logic [CAPACITY-1:0] shift_out;
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] vld;

  // entry count
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;

  // result register
  logic      out_v_r;
  logic      out_v_nxt;
  out_item_t out_item_r;
  out_item_t out_item_nxt;

  // accept whenever the result register is free or being drained
  assign in_chan.ready = !out_v_r || out_chan.ready;
  assign acc           = in_chan.valid && in_chan.ready;

  assign hit      = |match;
  assign full     = vld[CAPACITY-1];
  assign inserted = acc && (in_chan.data.command == CMD_LOOKUP) && !hit &&
                    in_chan.data.load_ok;
  assign evict    = inserted && full;

  assign bcast.key        = in_chan.data.key;
  assign bcast.lookup     = acc && (in_chan.data.command == CMD_LOOKUP);
  assign bcast.insert_new = inserted;

  // slot 0 is the oldest, the shift chain runs upward from it
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_top
      assign up_link[i] = '{valid: 1'b0, key: '0};
    end else begin : g_mid
      assign up_link[i] = cell_link[i+1];
    end

    if (i == 0) begin : g_bot
      assign down_vld[i] = 1'b1;
      // eviction shifts every slot down by one
      assign shift_in[i] = evict;
    end else begin : g_up
      assign down_vld[i] = cell_link[i-1].valid;
      assign shift_in[i] = shift_out[i-1];
    end

    assign vld[i] = cell_link[i].valid;

    lkc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .bcast      (bcast),
      .up_in      (up_link[i]),
      .down_valid (down_vld[i]),
      .shift_in   (shift_in[i]),
      .link_out   (cell_link[i]),
      .match      (match[i]),
      .shift_out  (shift_out[i])
    );
  end

  // count grows on an insert that does not evict
  assign cnt_nxt = (inserted && !evict) ? cnt_r + CW'(1) : cnt_r;

  always_comb begin
    out_v_nxt    = out_v_r;
    out_item_nxt = out_item_r;
    if (acc) begin
      out_v_nxt                  = 1'b1;
      out_item_nxt.hit           = hit;
      out_item_nxt.inserted      = inserted;
      out_item_nxt.evicted_valid = evict;
      out_item_nxt.evicted_key   = evict ? cell_link[0].key : '0;
      out_item_nxt.entry_count   = CNT_OUT_W'(cnt_nxt);
    end else if (out_chan.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_chan.valid = out_v_r;
  assign out_chan.data  = out_item_r;

  // the count always equals the number of valid slots
  `LKC_ASSERT(a_cnt_matches_valid, $countones(vld) == cnt_r, "count differs from valid slots")
  // valid slots are packed from slot 0 upward
  `LKC_ASSERT(a_valid_packed, (vld & (vld + CAPACITY'(1))) == '0, "valid slots not contiguous")
  // keys are unique, so at most one slot matches
  `LKC_ASSERT(a_single_match, $onehot0(match), "key stored in more than one slot")
  // eviction keeps the cache full
  `LKC_ASSERT_NEXT(a_evict_keeps_full, evict, full && $stable(cnt_r), "eviction changed fill")

endmodule
